FILE: rtl/i2r_pkg.sv
// Shared types, symbol codes and digit-to-symbol functions of the Roman numeral encoder.
package i2r_pkg;

	// ASCII codes of the Roman symbols
	localparam logic [7:0] SYM_I    = 8'h49;
	localparam logic [7:0] SYM_V    = 8'h56;
	localparam logic [7:0] SYM_X    = 8'h58;
	localparam logic [7:0] SYM_L    = 8'h4C;
	localparam logic [7:0] SYM_C    = 8'h43;
	localparam logic [7:0] SYM_D    = 8'h44;
	localparam logic [7:0] SYM_M    = 8'h4D;
	localparam logic [7:0] SYM_NONE = 8'h00;

	// Largest value that has a numeral
	localparam logic [11:0] MAX_VALID = 12'd3999;

	// Decimal position codes
	localparam logic [1:0] POS_ONES  = 2'd0;
	localparam logic [1:0] POS_TENS  = 2'd1;
	localparam logic [1:0] POS_HUNDS = 2'd2;
	localparam logic [1:0] POS_THOUS = 2'd3;

	typedef logic [3:0] digit_t;

	// Decimal digits of one number, index 3 is thousands
	typedef struct packed {
		logic            err;
		digit_t [3:0]    dig;
	} digits_t;

	// Ones symbol of a decimal position
	function automatic logic [7:0] ones_sym(input logic [1:0] pos);
		logic [7:0] s;
		unique case (pos)
			POS_ONES:  s = SYM_I;
			POS_TENS:  s = SYM_X;
			POS_HUNDS: s = SYM_C;
			POS_THOUS: s = SYM_M;
			default:   s = SYM_NONE;
		endcase
		return s;
	endfunction

	// Fives symbol of a decimal position
	function automatic logic [7:0] five_sym(input logic [1:0] pos);
		logic [7:0] s;
		unique case (pos)
			POS_ONES:  s = SYM_V;
			POS_TENS:  s = SYM_L;
			POS_HUNDS: s = SYM_D;
			default:   s = SYM_NONE;
		endcase
		return s;
	endfunction

	// Tens symbol of a decimal position
	function automatic logic [7:0] tens_sym(input logic [1:0] pos);
		logic [7:0] s;
		unique case (pos)
			POS_ONES:  s = SYM_X;
			POS_TENS:  s = SYM_C;
			POS_HUNDS: s = SYM_M;
			default:   s = SYM_NONE;
		endcase
		return s;
	endfunction

	// Number of symbols one decimal digit spells
	function automatic logic [2:0] digit_len(input digit_t d);
		logic [2:0] n;
		unique case (d)
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Symbol k of digit d at position pos
	function automatic logic [7:0] digit_sym(input digit_t d, input logic [1:0] k,
		input logic [1:0] pos);
		logic [7:0] s;
		priority if (d >= 4'd1 && d <= 4'd3) begin
			s = ones_sym(pos);
		end else if (d == 4'd4) begin
			s = (k == 2'd0) ? ones_sym(pos) : five_sym(pos);
		end else if (d >= 4'd5 && d <= 4'd8) begin
			s = (k == 2'd0) ? five_sym(pos) : ones_sym(pos);
		end else if (d == 4'd9) begin
			s = (k == 2'd0) ? ones_sym(pos) : tens_sym(pos);
		end else begin
			s = SYM_NONE;
		end
		return s;
	endfunction

endpackage

FILE: rtl/i2r_digits.sv
// Three-stage pipeline that splits a binary number into decimal digits and flags bad values.
module i2r_digits (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [11:0]      number,
	output logic             dg_valid,
	input  logic             dg_ready,
	output i2r_pkg::digits_t dg_digits
);

	logic                valid_s1, valid_s2, valid_s3;
	logic [11:0]         number_s1;
	logic                err_s2;
	i2r_pkg::digit_t     thou_s2;
	logic [9:0]          rem_s2;
	i2r_pkg::digits_t    digits_s3;

	logic                adv_s1, adv_s2, adv_s3;

	// advance each stage when it is empty or its word moves on
	assign adv_s3   = !valid_s3 || dg_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign dg_valid  = valid_s3;
	assign dg_digits = digits_s3;

	// thousands digit and remainder below one thousand
	logic                err_a;
	i2r_pkg::digit_t     thou_a;
	logic [11:0]         base_a;
	logic [9:0]          rem_a;

	always_comb begin
		err_a  = (number_s1 == 12'd0) || (number_s1 > i2r_pkg::MAX_VALID);
		thou_a = 4'd0;
		base_a = 12'd0;
		for (int k = 1; k <= 3; k++) begin
			if (number_s1 >= 12'(k * 1000)) begin
				thou_a = 4'(k);
				base_a = 12'(k * 1000);
			end
		end
		rem_a = 10'(number_s1 - base_a);
	end

	// hundreds, tens and ones digits from the remainder
	i2r_pkg::digit_t     hund_b, tens_b, ones_b;
	logic [9:0]          base_h;
	logic [6:0]          rem_b;
	logic [6:0]          base_t;

	always_comb begin
		hund_b = 4'd0;
		base_h = 10'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_s2 >= 10'(k * 100)) begin
				hund_b = 4'(k);
				base_h = 10'(k * 100);
			end
		end
		rem_b  = 7'(rem_s2 - base_h);
		tens_b = 4'd0;
		base_t = 7'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_b >= 7'(k * 10)) begin
				tens_b = 4'(k);
				base_t = 7'(k * 10);
			end
		end
		ones_b = 4'(rem_b - base_t);
	end

	// hold valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// load stage payloads
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) number_s1 <= number;
		if (adv_s2 && valid_s1) begin
			err_s2  <= err_a;
			thou_s2 <= thou_a;
			rem_s2  <= rem_a;
		end
		if (adv_s3 && valid_s2) begin
			digits_s3.err    <= err_s2;
			digits_s3.dig[3] <= thou_s2;
			digits_s3.dig[2] <= hund_b;
			digits_s3.dig[1] <= tens_b;
			digits_s3.dig[0] <= ones_b;
		end
	end

endmodule

FILE: rtl/i2r_sequencer.sv
// Symbol sequencer: walks the digits of one number and emits one Roman symbol word per cycle while out_ready is high.
module i2r_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ld_valid,
	output logic             ld_ready,
	input  i2r_pkg::digits_t ld_digits,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       symbol,
	output logic             last,
	output logic             error
);

	logic                    act_q;
	i2r_pkg::digits_t        dig_q;
	logic [1:0]              pos_q;
	logic [1:0]              cnt_q;
	logic                    out_valid_q;
	logic [7:0]              symbol_q;
	logic                    last_q;
	logic                    error_q;

	i2r_pkg::digit_t         cur_d;
	logic [2:0]              cur_len;
	logic                    end_dig;
	logic                    nxt_found;
	logic [1:0]              nxt_pos;
	logic [1:0]              first_pos;
	logic                    word_last;
	logic [7:0]              word_sym;
	logic                    fire;
	logic                    load;

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign error     = error_q;

	// current digit and the next nonzero digit below it
	always_comb begin
		cur_d     = dig_q.dig[pos_q];
		cur_len   = i2r_pkg::digit_len(cur_d);
		end_dig   = ({1'b0, cnt_q} == 3'(cur_len - 3'd1));
		nxt_found = 1'b0;
		nxt_pos   = 2'd0;
		for (int p = 0; p < 4; p++) begin
			if (2'(p) < pos_q && dig_q.dig[p] != 4'd0) begin
				nxt_found = 1'b1;
				nxt_pos   = 2'(p);
			end
		end
		first_pos = 2'd0;
		for (int p = 0; p < 4; p++) begin
			if (ld_digits.dig[p] != 4'd0) first_pos = 2'(p);
		end
		word_last = dig_q.err || (end_dig && !nxt_found);
		word_sym  = dig_q.err ? i2r_pkg::SYM_NONE
			: i2r_pkg::digit_sym(cur_d, cnt_q, pos_q);
	end

	// emit when a run is active and the output slot frees up
	assign fire     = act_q && (!out_valid_q || out_ready);
	assign ld_ready = !act_q || (fire && word_last);
	assign load     = ld_valid && ld_ready;

	// advance the walk, take a new number when idle or when the run ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				act_q <= 1'b1;
			end else if (fire && word_last) begin
				act_q <= 1'b0;
			end
		end
	end

	// hold digits, position and result word
	always_ff @(posedge clk) begin
		if (fire) begin
			symbol_q <= word_sym;
			last_q   <= word_last;
			error_q  <= dig_q.err;
		end
		if (load) begin
			dig_q <= ld_digits;
			pos_q <= first_pos;
			cnt_q <= 2'd0;
		end else if (fire) begin
			if (end_dig) begin
				pos_q <= nxt_pos;
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

FILE: rtl/integer_to_roman_encoder_core.sv
// Top level of the integer to Roman numeral encoder.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_ready  | number[11:0]
//   output   | out_valid / out_ready| symbol[7:0], last, error
//
// Each number yields one output word per symbol, 1 to 15 words; the output
// register gives one word per cycle while out_ready is high. Zero and
// out-of-range numbers yield a single error word. A number passes stages s1,
// s2, s3, the sequencer digit register and the output register in that order.
// Reset clears all valid bits; the block keeps no state between numbers.
// A stall on out_ready holds the output word and backs up the digit pipeline.
module integer_to_roman_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  symbol,
	output logic        last,
	output logic        error
);

	logic             dg_valid;
	logic             dg_ready;
	i2r_pkg::digits_t dg_digits;

	// split into decimal digits
	i2r_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.number    (number),
		.dg_valid  (dg_valid),
		.dg_ready  (dg_ready),
		.dg_digits (dg_digits)
	);

	// spell the digits as symbols
	i2r_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (dg_valid),
		.ld_ready  (dg_ready),
		.ld_digits (dg_digits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.last      (last),
		.error     (error)
	);

	// an error word carries no symbol and ends its run
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> symbol == i2r_pkg::SYM_NONE && last)
		else $error("error word with symbol or without last");

	// a good word carries a Roman symbol
	a_sym_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> symbol == i2r_pkg::SYM_I || symbol == i2r_pkg::SYM_V ||
			symbol == i2r_pkg::SYM_X || symbol == i2r_pkg::SYM_L ||
			symbol == i2r_pkg::SYM_C || symbol == i2r_pkg::SYM_D ||
			symbol == i2r_pkg::SYM_M)
		else $error("illegal symbol code");

	// a word that follows an error word starts a new run
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && error ##1 out_valid |-> $past(last))
		else $error("error word not closing its run");

endmodule
